>>> src/osc_packet_splitter_core_macros.svh
// ----------------------------------------------------------------------------
// OSC packet splitter assertion macros
// Shared assertion forms for the checker, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef OSC_PACKET_SPLITTER_CORE_MACROS_SVH
`define OSC_PACKET_SPLITTER_CORE_MACROS_SVH

// Assertion that is switched off while reset is held.
`define OSC_PS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Assertion that is also checked during reset.
`define OSC_PS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/osc_ps_pkg.sv
// ----------------------------------------------------------------------------
// OSC packet splitter package
// Sizes, codes and shared types of the packet splitter.
// ----------------------------------------------------------------------------
package osc_ps_pkg;

  localparam int MAX_PARAMS       = 10;
  localparam int MAX_PACKET_BYTES = 1024;
  localparam int TAG_DEPTH        = 11;
  localparam int TAG_IDX_W        = $clog2(TAG_DEPTH);

  localparam int WORD_LIMIT = MAX_PACKET_BYTES / 4;
  localparam int WPOS_W     = $clog2(WORD_LIMIT + 1);
  localparam int BYTE_W     = WPOS_W + 2;

  localparam int WORD_W = 32;
  localparam int IDX_W  = 4;
  localparam int OFF_W  = 10;
  localparam int LEN_W  = 11;
  localparam int CNT_W  = 4;
  localparam int KIND_W = 2;
  localparam int TYPE_W = 2;

  localparam int DATA_W = 64;
  localparam int PAD_W  = DATA_W - (IDX_W + OFF_W + LEN_W + WORD_W + CNT_W);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [KIND_W-1:0] KIND_ADDR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TAGS  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PARAM = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd3;

  localparam logic [TYPE_W-1:0] TYPE_INT = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_FLT = 2'd1;
  localparam logic [TYPE_W-1:0] TYPE_STR = 2'd2;

  localparam logic [7:0] TAG_INT = 8'h69;
  localparam logic [7:0] TAG_STR = 8'h73;
  localparam logic [7:0] TAG_FLT = 8'h66;

  typedef enum logic [6:0] {
    PH_ADDR = 7'b0000001,
    PH_TAGS = 7'b0000010,
    PH_INT  = 7'b0000100,
    PH_STR  = 7'b0001000,
    PH_FLT  = 7'b0010000,
    PH_SKIP = 7'b0100000,
    PH_DONE = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  param_index;
    logic [TYPE_W-1:0] type_code;
    logic [OFF_W-1:0]  offset_bytes;
    logic [LEN_W-1:0]  length_bytes;
    logic [WORD_W-1:0] value;
    logic [CNT_W-1:0]  count;
    logic              end_of_run;
  } res_t;

  // Up to two results produced by one packet word.
  typedef struct packed {
    logic [1:0] n_res;
    res_t       r0;
    res_t       r1;
  } push_t;

  // Layout of out_tdata, param_index in the lowest bits.
  typedef struct packed {
    logic [PAD_W-1:0]  pad;
    logic [CNT_W-1:0]  count;
    logic [WORD_W-1:0] value;
    logic [LEN_W-1:0]  length_bytes;
    logic [OFF_W-1:0]  offset_bytes;
    logic [IDX_W-1:0]  param_index;
  } out_data_t;

  // Layout of out_tuser, kind in the lowest bits.
  typedef struct packed {
    logic [TYPE_W-1:0] type_code;
    logic [KIND_W-1:0] kind;
  } out_user_t;

endpackage

>>> src/osc_ps_outq.sv
// ----------------------------------------------------------------------------
// OSC packet splitter result queue
// Small queue that takes up to two results a cycle and hands out one while the reader is ready.
// ----------------------------------------------------------------------------
module osc_ps_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  osc_ps_pkg::push_t push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output osc_ps_pkg::res_t  out_res
);

  osc_ps_pkg::res_t                   q_r [osc_ps_pkg::QDEPTH];
  logic [osc_ps_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [osc_ps_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [osc_ps_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic [osc_ps_pkg::QPTR_W-1:0]      wr_ptr_p1;
  logic                               pop;

  // Room is judged before this cycle's pop, so a request never overfills.
  assign room      = (cnt_r <= osc_ps_pkg::QCNT_W'(osc_ps_pkg::QDEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_res   = q_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + osc_ps_pkg::QPTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + osc_ps_pkg::QPTR_W'(push.n_res);
    rd_ptr_nxt = rd_ptr_r + osc_ps_pkg::QPTR_W'(pop);
    cnt_nxt    = cnt_r + osc_ps_pkg::QCNT_W'(push.n_res) - osc_ps_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < osc_ps_pkg::QDEPTH; i++) begin
      if (push.n_res != 2'd0 && wr_ptr_r == osc_ps_pkg::QPTR_W'(i)) begin
        q_r[i] <= push.r0;
      end else if (push.n_res == 2'd2 && wr_ptr_p1 == osc_ps_pkg::QPTR_W'(i)) begin
        q_r[i] <= push.r1;
      end
    end
  end

endmodule

>>> src/osc_ps_parser.sv
// ----------------------------------------------------------------------------
// OSC packet splitter parser
// Input word register, parse state, type tag store and result forming.
// ----------------------------------------------------------------------------
module osc_ps_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [osc_ps_pkg::WORD_W-1:0] in_word,
  input  logic                          in_last,
  input  logic                          q_room,
  output osc_ps_pkg::push_t             push
);

  // Input stage
  logic                          in_vld_r;
  logic [osc_ps_pkg::WORD_W-1:0] in_word_r;
  logic                          in_last_r;
  logic                          adv;

  // Parse state
  osc_ps_pkg::phase_t            phase_r, phase_nxt;
  logic [osc_ps_pkg::IDX_W-1:0]  ps_r, ps_nxt;
  logic [osc_ps_pkg::WPOS_W-1:0] wp_r, wp_nxt;
  logic [osc_ps_pkg::BYTE_W-1:0] start_r, start_nxt;
  logic [7:0]                    tag_r   [osc_ps_pkg::TAG_DEPTH];
  logic [7:0]                    tag_nxt [osc_ps_pkg::TAG_DEPTH];

  logic                          in_range;
  logic                          zero_end;
  logic [osc_ps_pkg::BYTE_W-1:0] end_b;
  logic [osc_ps_pkg::WPOS_W-1:0] rel_w;

  assign adv      = in_vld_r && q_room;
  assign in_ready = !in_vld_r || adv;

  assign in_range = (wp_r < osc_ps_pkg::WPOS_W'(osc_ps_pkg::WORD_LIMIT));
  assign zero_end = (in_word_r[7:0] == 8'd0);
  assign end_b    = {wp_r, 2'b00} + osc_ps_pkg::BYTE_W'(4);
  // Words since the start of the type tag string.
  assign rel_w    = wp_r - start_r[osc_ps_pkg::BYTE_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r <= in_word;
      in_last_r <= in_last;
    end
  end

  // Tag byte k of the string (k = 1 after the comma) lands in entry k-1.
  // The store is read through these merged values so that a one-word tag
  // string is seen in the same cycle.
  always_comb begin
    for (int j = 0; j < osc_ps_pkg::TAG_DEPTH; j++) begin
      tag_nxt[j] = tag_r[j];
      if (phase_r == osc_ps_pkg::PH_TAGS && in_range &&
          rel_w == osc_ps_pkg::WPOS_W'((j + 1) >> 2)) begin
        tag_nxt[j] = in_word_r[31 - 8 * ((j + 1) & 3) -: 8];
      end
    end
  end

  always_comb begin
    logic [7:0]                    tag;
    logic                          np_stop;
    osc_ps_pkg::phase_t            np_phase;
    logic                          has_a;
    osc_ps_pkg::res_t              res_a;
    osc_ps_pkg::res_t              res_d;

    phase_nxt = phase_r;
    ps_nxt    = ps_r;
    wp_nxt    = wp_r;
    start_nxt = start_r;
    has_a     = 1'b0;
    res_a     = '0;
    res_d     = '0;
    push      = '0;

    // Tag of the next parameter; past the store it reads as the end.
    tag = 8'd0;
    if (ps_r < osc_ps_pkg::IDX_W'(osc_ps_pkg::TAG_DEPTH)) begin
      tag = tag_nxt[ps_r[osc_ps_pkg::TAG_IDX_W-1:0]];
    end
    np_stop = (ps_r >= osc_ps_pkg::IDX_W'(osc_ps_pkg::MAX_PARAMS)) || (tag == 8'd0);
    case (tag)
      osc_ps_pkg::TAG_INT: np_phase = osc_ps_pkg::PH_INT;
      osc_ps_pkg::TAG_STR: np_phase = osc_ps_pkg::PH_STR;
      osc_ps_pkg::TAG_FLT: np_phase = osc_ps_pkg::PH_FLT;
      default:             np_phase = osc_ps_pkg::PH_SKIP;
    endcase
    if (np_stop) begin
      np_phase = osc_ps_pkg::PH_DONE;
    end

    if (in_range) begin
      wp_nxt = wp_r + osc_ps_pkg::WPOS_W'(1);
      case (phase_r)
        osc_ps_pkg::PH_ADDR: begin
          if (zero_end) begin
            has_a              = 1'b1;
            res_a.kind         = osc_ps_pkg::KIND_ADDR;
            res_a.length_bytes = osc_ps_pkg::LEN_W'(end_b);
            phase_nxt          = osc_ps_pkg::PH_TAGS;
            start_nxt          = end_b;
          end
        end
        osc_ps_pkg::PH_TAGS: begin
          if (zero_end) begin
            has_a              = 1'b1;
            res_a.kind         = osc_ps_pkg::KIND_TAGS;
            res_a.offset_bytes = start_r[osc_ps_pkg::OFF_W-1:0];
            res_a.length_bytes = osc_ps_pkg::LEN_W'(end_b - start_r);
            phase_nxt          = np_phase;
            if (!np_stop) begin
              ps_nxt    = ps_r + osc_ps_pkg::IDX_W'(1);
              start_nxt = end_b;
            end
          end
        end
        osc_ps_pkg::PH_INT, osc_ps_pkg::PH_FLT: begin
          has_a              = 1'b1;
          res_a.kind         = osc_ps_pkg::KIND_PARAM;
          res_a.param_index  = ps_r - osc_ps_pkg::IDX_W'(1);
          res_a.type_code    = (phase_r == osc_ps_pkg::PH_INT) ?
                               osc_ps_pkg::TYPE_INT : osc_ps_pkg::TYPE_FLT;
          res_a.offset_bytes = start_r[osc_ps_pkg::OFF_W-1:0];
          res_a.length_bytes = osc_ps_pkg::LEN_W'(4);
          res_a.value        = in_word_r;
          phase_nxt          = np_phase;
          if (!np_stop) begin
            ps_nxt    = ps_r + osc_ps_pkg::IDX_W'(1);
            start_nxt = end_b;
          end
        end
        osc_ps_pkg::PH_STR: begin
          if (zero_end) begin
            has_a              = 1'b1;
            res_a.kind         = osc_ps_pkg::KIND_PARAM;
            res_a.param_index  = ps_r - osc_ps_pkg::IDX_W'(1);
            res_a.type_code    = osc_ps_pkg::TYPE_STR;
            res_a.offset_bytes = start_r[osc_ps_pkg::OFF_W-1:0];
            res_a.length_bytes = osc_ps_pkg::LEN_W'(end_b - start_r);
            phase_nxt          = np_phase;
            if (!np_stop) begin
              ps_nxt    = ps_r + osc_ps_pkg::IDX_W'(1);
              start_nxt = end_b;
            end
          end
        end
        osc_ps_pkg::PH_SKIP: begin
          // An unknown tag uses up this word without a result.
          phase_nxt = np_phase;
          if (!np_stop) begin
            ps_nxt    = ps_r + osc_ps_pkg::IDX_W'(1);
            start_nxt = end_b;
          end
        end
        default: begin
        end
      endcase
    end

    res_d.kind       = osc_ps_pkg::KIND_DONE;
    res_d.count      = ps_nxt;
    res_d.end_of_run = 1'b1;

    if (adv) begin
      if (has_a && in_last_r) begin
        push.n_res = 2'd2;
        push.r0    = res_a;
        push.r1    = res_d;
      end else if (has_a) begin
        push.n_res         = 2'd1;
        push.r0            = res_a;
        push.r0.end_of_run = 1'b1;
      end else if (in_last_r) begin
        push.n_res = 2'd1;
        push.r0    = res_d;
      end
    end

    // The last word of a packet returns the parser to its reset state.
    if (in_last_r) begin
      phase_nxt = osc_ps_pkg::PH_ADDR;
      ps_nxt    = '0;
      wp_nxt    = '0;
      start_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= osc_ps_pkg::PH_ADDR;
      ps_r    <= '0;
      wp_r    <= '0;
      start_r <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      ps_r    <= ps_nxt;
      wp_r    <= wp_nxt;
      start_r <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < osc_ps_pkg::TAG_DEPTH; j++) begin
        tag_r[j] <= tag_nxt[j];
      end
    end
  end

endmodule

>>> src/osc_packet_splitter_core.sv
// ----------------------------------------------------------------------------
// OSC packet splitter core
// Splits an OSC packet, one big-endian word per request, into address,
// type tag and parameter results with byte offsets and lengths, and a done result.
// ----------------------------------------------------------------------------
// The core takes one packet word per clock cycle while the result queue has
// room. A word is registered in the input word register, and its results in
// the result queue before they are reported. Each word is parsed by logic
// between the input word register and a four-entry result queue. A word may
// cause up to two results (an address, tag or parameter result and the packet
// done result on the last word); each result takes its own output transfer.
// The input side stalls only while the result queue has fewer than two free
// entries. After the word flagged with tlast, the parser is back in its reset state for the next packet.
module osc_packet_splitter_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [osc_ps_pkg::WORD_W-1:0] in_tdata,  // word[31:0]
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // param_index[3:0], offset_bytes[13:4], length_bytes[24:14],
  // value[56:25], count[60:57], zero[63:61]
  output logic [osc_ps_pkg::DATA_W-1:0] out_tdata,
  output logic [3:0]                    out_tuser, // kind[1:0], type_code[3:2]
  output logic                          out_tlast
);

  osc_ps_pkg::push_t     push;
  logic                  q_room;
  osc_ps_pkg::res_t      out_res;
  osc_ps_pkg::out_data_t dout;
  osc_ps_pkg::out_user_t uout;

  osc_ps_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_word  (in_tdata),
    .in_last  (in_tlast),
    .q_room   (q_room),
    .push     (push)
  );

  osc_ps_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (q_room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  always_comb begin
    dout              = '0;
    dout.param_index  = out_res.param_index;
    dout.offset_bytes = out_res.offset_bytes;
    dout.length_bytes = out_res.length_bytes;
    dout.value        = out_res.value;
    dout.count        = out_res.count;
    uout.kind         = out_res.kind;
    uout.type_code    = out_res.type_code;
  end

  assign out_tdata = dout;
  assign out_tuser = uout;
  assign out_tlast = out_res.end_of_run;

endmodule

>>> src/osc_ps_checker.sv
// ----------------------------------------------------------------------------
// OSC packet splitter checker
// Port-level assertions on the splitter core, attached by bind.
// ----------------------------------------------------------------------------
`include "osc_packet_splitter_core_macros.svh"

module osc_ps_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [osc_ps_pkg::DATA_W-1:0] out_tdata,
  input logic [3:0]                    out_tuser,
  input logic                          out_tlast
);

  osc_ps_pkg::out_data_t d;
  osc_ps_pkg::out_user_t u;

  assign d = out_tdata;
  assign u = out_tuser;

  // Reset empties the result queue and opens the input side.
  `OSC_PS_ASSERT_RST(a_reset_state, (!rst_n |=> (!out_tvalid && in_tready)), "bad state after reset")

  // A done result always closes the run of results of its word.
  `OSC_PS_ASSERT(a_done_last, ((out_tvalid && u.kind == osc_ps_pkg::KIND_DONE) |-> out_tlast), "done result without tlast")

  // Only a done result carries a parameter count, and it has no offset or length.
  `OSC_PS_ASSERT(a_count_done, (out_tvalid |-> ((u.kind == osc_ps_pkg::KIND_DONE) ? (d.offset_bytes == '0 && d.length_bytes == '0) : (d.count == '0))), "count or extent on wrong result kind")

  `OSC_PS_ASSERT(a_valid_hold, ((out_tvalid && !out_tready) |=> out_tvalid), "result request dropped while stalled")

  `OSC_PS_ASSERT(a_data_hold, ((out_tvalid && !out_tready) |=> ($stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))), "stalled result changed")

endmodule

bind osc_packet_splitter_core osc_ps_checker u_osc_ps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
